[hdl/masked_byte_pattern_search_assert.svh]
// Assertion macros shared by the masked byte pattern search modules
`ifndef MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define MBPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
	else $error("mbps assertion failed");

`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
	else $error("mbps assertion failed");

`else

`define MBPS_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define MBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/mbps_pkg.sv]
// Types and constants of the masked byte pattern search
package mbps_pkg;

	localparam int BYTE_BITS          = 8;
	localparam int CFG_DATA_BITS      = 64;
	localparam int CFG_INDEX_BITS     = 2;
	localparam int CARE_BITS          = 16;
	localparam int LEN_BITS           = 5;
	localparam int RESULT_OFFSET_BITS = 32;
	localparam int PATTERN_BYTES      = 16;
	localparam int PATTERN_SEL_BITS   = 4;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_PATTERN_LOW    = 2'd0,
		CFG_PATTERN_HIGH   = 2'd1,
		CFG_CARE_MASK      = 2'd2,
		CFG_PATTERN_LENGTH = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [BYTE_BITS-1:0] pattern;
		logic                 care;
	} cmp_t;

	typedef struct packed {
		logic                          found;
		logic [RESULT_OFFSET_BITS-1:0] offset;
	} result_t;

endpackage

[hdl/mbps_cell.sv]
// One window cell: holds a past byte, shifts it on, compares it to its pattern byte
module mbps_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           shift,
	input  logic [mbps_pkg::BYTE_BITS-1:0] din,
	input  mbps_pkg::cmp_t                 cmp,
	output logic [mbps_pkg::BYTE_BITS-1:0] dout,
	output logic                           miss
);
	import mbps_pkg::*;

	logic [BYTE_BITS-1:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;
	assign miss = cmp.care && (byte_q != cmp.pattern);

endmodule

[hdl/mbps_outq.sv]
// Two-entry result queue: output register plus skid entry

`include "masked_byte_pattern_search_assert.svh"

module mbps_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mbps_pkg::result_t push_item,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output mbps_pkg::result_t out_item
);
	import mbps_pkg::*;

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_item_q;
	result_t skid_item_q;
	logic    pop;

	assign pop       = out_valid_q && out_ready;
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= push;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_item_q <= skid_item_q;
				if (push) begin
					skid_item_q <= push_item;
				end
			end else if (push) begin
				out_item_q <= push_item;
			end
		end else if (push) begin
			if (out_valid_q) begin
				skid_item_q <= push_item;
			end else begin
				out_item_q <= push_item;
			end
		end
	end

	`MBPS_ASSERT_IMP(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q)
	`MBPS_ASSERT_IMP(a_no_push_when_full, clk, arst_n, skid_valid_q, !push)
	`MBPS_ASSERT_NEXT(a_drain_empties, clk, arst_n, pop && !skid_valid_q && !push, !out_valid_q)

endmodule

[hdl/masked_byte_pattern_search.sv]
// Top level of the masked byte pattern search
//
// Streams one byte per item and reports, once per range, the start offset of the first
// place where the configured pattern matches with all its bytes inside the range, or a
// not-found result when the range ends without a match. A row of MAX_PATTERN-1 cells
// holds the recent bytes and all pattern positions are compared in the same cycle, so a
// new byte is accepted every clock. Results leave through a two-entry queue; input
// stalls only while both entries hold results not yet taken. Configuration writes take
// effect on the next item; the user makes them while the block is idle, not enforced.

`include "masked_byte_pattern_search_assert.svh"

module masked_byte_pattern_search #(
	parameter int MAX_PATTERN = 16,
	parameter int OFFSET_BITS = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [mbps_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  logic [mbps_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [mbps_pkg::BYTE_BITS-1:0]          data_byte,
	input  logic                                    range_start,
	input  logic                                    range_end,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic                                    found,
	output logic [mbps_pkg::RESULT_OFFSET_BITS-1:0] match_offset
);
	import mbps_pkg::*;

	localparam int WIN = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

	logic [CFG_DATA_BITS-1:0] pattern_low_q;
	logic [CFG_DATA_BITS-1:0] pattern_high_q;
	logic [CARE_BITS-1:0]     care_mask_q;
	logic [LEN_BITS-1:0]      pattern_length_q;

	logic [OFFSET_BITS-1:0] pos_q;
	logic                   reported_q;

	logic                          acc;
	logic [OFFSET_BITS-1:0]        pos_eff;
	logic                          rep_eff;
	logic [LEN_BITS-1:0]           len;
	logic [LEN_BITS-1:0]           last_sel;
	logic                          fit;
	logic                          last_miss;
	logic                          any_miss;
	logic                          hit;
	logic                          match_now;
	logic [OFFSET_BITS-1:0]        off;
	logic [RESULT_OFFSET_BITS-1:0] off32;
	logic                          res_valid;
	logic                          q_space;
	result_t                       res;
	result_t                       out_item;

	logic [BYTE_BITS-1:0] pat_bytes [PATTERN_BYTES];
	logic [BYTE_BITS-1:0] win_byte  [WIN];
	logic [WIN-1:0]       cell_miss;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
			care_mask_q      <= '0;
			pattern_length_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_PATTERN_LOW:    pattern_low_q    <= cfg_data;
				CFG_PATTERN_HIGH:   pattern_high_q   <= cfg_data;
				CFG_CARE_MASK:      care_mask_q      <= cfg_data[CARE_BITS-1:0];
				CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int i = 0; i < PATTERN_BYTES / 2; i++) begin
			pat_bytes[i]                     = pattern_low_q[i*BYTE_BITS +: BYTE_BITS];
			pat_bytes[i + PATTERN_BYTES / 2] = pattern_high_q[i*BYTE_BITS +: BYTE_BITS];
		end
	end

	assign acc     = in_valid && in_ready;
	assign pos_eff = range_start ? '0 : pos_q;
	assign rep_eff = range_start ? 1'b0 : reported_q;
	assign len     = (pattern_length_q > LEN_BITS'(MAX_PATTERN)) ?
		LEN_BITS'(MAX_PATTERN) : pattern_length_q;

	for (genvar k = 0; k < WIN; k++) begin : g_cell
		logic [LEN_BITS-1:0] sel;
		cmp_t                cmp;

		assign sel         = len - LEN_BITS'(k) - LEN_BITS'(2);
		assign cmp.pattern = pat_bytes[sel[PATTERN_SEL_BITS-1:0]];
		assign cmp.care    = (LEN_BITS'(k) + LEN_BITS'(2) <= len) &&
			care_mask_q[sel[PATTERN_SEL_BITS-1:0]];

		mbps_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (acc),
			.din    ((k == 0) ? data_byte : win_byte[(k == 0) ? 0 : k - 1]),
			.cmp    (cmp),
			.dout   (win_byte[k]),
			.miss   (cell_miss[k])
		);
	end

	assign last_sel  = len - LEN_BITS'(1);
	assign last_miss = care_mask_q[last_sel[PATTERN_SEL_BITS-1:0]] &&
		(data_byte != pat_bytes[last_sel[PATTERN_SEL_BITS-1:0]]);
	assign any_miss  = |cell_miss;
	assign fit       = (OFFSET_BITS+1)'(len) <= ({1'b0, pos_eff} + (OFFSET_BITS+1)'(1));
	assign hit       = (len == '0) || (fit && !any_miss && !last_miss);
	assign match_now = !rep_eff && hit;
	assign off       = (len == '0) ? '0 : pos_eff + OFFSET_BITS'(1) - OFFSET_BITS'(len);

	if (OFFSET_BITS >= RESULT_OFFSET_BITS) begin : g_off_cut
		assign off32 = off[RESULT_OFFSET_BITS-1:0];
	end else begin : g_off_ext
		assign off32 = {{(RESULT_OFFSET_BITS-OFFSET_BITS){1'b0}}, off};
	end

	assign res_valid  = match_now || (range_end && !rep_eff);
	assign res.found  = match_now;
	assign res.offset = match_now ? off32 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			reported_q <= 1'b0;
		end else if (acc) begin
			if (range_end) begin
				pos_q      <= '0;
				reported_q <= 1'b0;
			end else begin
				pos_q      <= (&pos_eff) ? pos_eff : pos_eff + OFFSET_BITS'(1);
				reported_q <= rep_eff || match_now;
			end
		end
	end

	assign in_ready = q_space;

	mbps_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc && res_valid),
		.push_item (res),
		.space     (q_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	assign found        = out_item.found;
	assign match_offset = out_item.offset;

	`MBPS_ASSERT_NEXT(a_match_sets_reported, clk, arst_n, acc && match_now && !range_end, reported_q)
	`MBPS_ASSERT_NEXT(a_end_clears_state, clk, arst_n, acc && range_end, pos_q == '0 && !reported_q)
	`MBPS_ASSERT_NEXT(a_position_holds, clk, arst_n, !acc, $stable(pos_q))

endmodule

[verif/masked_byte_pattern_search_test.sv]
// Self-checking testbench of masked_byte_pattern_search: directed and random byte ranges
module masked_byte_pattern_search_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mbps_pkg::*;

	localparam int WINDOW_DEPTH = PATTERN_BYTES - 1;
	localparam longint unsigned POSITION_MAX = 64'h0000_0000_FFFF_FFFF;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_LIMIT = 10;
	localparam int PHASE_ITEMS = 175;

	typedef struct packed {
		logic [BYTE_BITS-1:0] data;
		logic                 first;
		logic                 last;
	} scan_item_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0]     cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]      cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [BYTE_BITS-1:0]          data_byte = '0;
	logic                          range_start = 1'b0;
	logic                          range_end = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          found;
	logic [RESULT_OFFSET_BITS-1:0] match_offset;

	logic [2*CFG_DATA_BITS-1:0] pattern_bytes;
	logic [CARE_BITS-1:0]       care_bits;
	logic [LEN_BITS-1:0]        length_setting;
	logic [BYTE_BITS-1:0]       recent_bytes [WINDOW_DEPTH];
	longint unsigned            scan_position;
	logic                       match_seen;

	scan_item_t byte_queue [$];
	result_t    expected_results [$];
	scan_item_t active_item;
	result_t    head_result;

	bit input_idle = 1'b0;
	bit output_idle = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int quiet_cycles = 0;

	int items_queued = 0;
	int items_sent = 0;
	int results_checked = 0;
	int found_count = 0;
	int miss_count = 0;
	int mismatches = 0;
	int phases_run = 0;

	masked_byte_pattern_search dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.range_start  (range_start),
		.range_end    (range_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_offset (match_offset)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void flag_error(string msg);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("MISMATCH at %0t: %s", $time, msg);
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int effective_length();
		return (length_setting > PATTERN_BYTES) ? PATTERN_BYTES : int'(length_setting);
	endfunction

	function automatic void scan_byte(scan_item_t entry);
		int unsigned span;
		logic hit;
		logic [BYTE_BITS-1:0] seen;
		result_t res;
		if (entry.first) begin
			scan_position = 0;
			match_seen = 1'b0;
		end
		span = effective_length();
		if (!match_seen) begin
			hit = (span == 0) || (longint'(span) <= scan_position + 1);
			for (int j = 0; j < span; j++) begin
				if (j == span - 1)
					seen = entry.data;
				else
					seen = recent_bytes[span - 2 - j];
				if (care_bits[j] && seen != pattern_bytes[8*j +: 8])
					hit = 1'b0;
			end
			if (hit) begin
				res.found = 1'b1;
				if (span == 0)
					res.offset = '0;
				else
					res.offset = RESULT_OFFSET_BITS'(scan_position + 1 - span);
				expected_results.push_back(res);
				match_seen = 1'b1;
			end
		end
		for (int k = WINDOW_DEPTH - 1; k > 0; k--)
			recent_bytes[k] = recent_bytes[k - 1];
		recent_bytes[0] = entry.data;
		if (scan_position < POSITION_MAX)
			scan_position++;
		if (entry.last) begin
			if (!match_seen) begin
				res.found = 1'b0;
				res.offset = '0;
				expected_results.push_back(res);
			end
			scan_position = 0;
			match_seen = 1'b0;
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				scan_byte(active_item);
				items_sent++;
			end
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (byte_queue.size() > 0) begin
				active_item = byte_queue.pop_front();
				data_byte <= active_item.data;
				range_start <= active_item.first;
				range_end <= active_item.last;
				in_valid <= 1'b1;
				send_gap = input_idle ? pick_gap() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					flag_error($sformatf("unexpected result found=%0b offset=%0d",
						found, match_offset));
				end else begin
					head_result = expected_results.pop_front();
					results_checked++;
					if (head_result.found)
						found_count++;
					else
						miss_count++;
					if (found !== head_result.found || match_offset !== head_result.offset)
						flag_error($sformatf("expected found=%0b offset=%0d, got found=%0b offset=%0d",
							head_result.found, head_result.offset, found, match_offset));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = HOLD_OFF_CYCLES;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				stall_left = output_idle ? pick_gap() : 0;
				out_ready <= (stall_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
			$display("masked_byte_pattern_search test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic write_register(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			CFG_PATTERN_LOW:    pattern_bytes[CFG_DATA_BITS-1:0] = value;
			CFG_PATTERN_HIGH:   pattern_bytes[2*CFG_DATA_BITS-1:CFG_DATA_BITS] = value;
			CFG_CARE_MASK:      care_bits = value[CARE_BITS-1:0];
			CFG_PATTERN_LENGTH: length_setting = value[LEN_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic load_pattern(logic [CFG_DATA_BITS-1:0] lo, logic [CFG_DATA_BITS-1:0] hi,
			logic [CARE_BITS-1:0] care, logic [LEN_BITS-1:0] len);
		write_register(CFG_PATTERN_LOW, lo);
		write_register(CFG_PATTERN_HIGH, hi);
		write_register(CFG_CARE_MASK, CFG_DATA_BITS'(care));
		write_register(CFG_PATTERN_LENGTH, CFG_DATA_BITS'(len));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic settle();
		@(negedge clk);
		while (byte_queue.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		phases_run++;
	endtask

	function automatic void add_item(logic [BYTE_BITS-1:0] data, logic first, logic last);
		scan_item_t entry;
		entry.data = data;
		entry.first = first;
		entry.last = last;
		byte_queue.push_back(entry);
		items_queued++;
	endfunction

	function automatic logic [BYTE_BITS-1:0] pick_byte();
		if ($urandom_range(1))
			return BYTE_BITS'($urandom);
		return pattern_bytes[8*$urandom_range(PATTERN_BYTES - 1) +: 8];
	endfunction

	function automatic void add_search_range();
		int size;
		int spot;
		int span;
		logic [BYTE_BITS-1:0] body [$];
		span = effective_length();
		size = ($urandom_range(9) == 0) ? $urandom_range(24, 64) : $urandom_range(1, 20);
		for (int i = 0; i < size; i++)
			body.push_back(pick_byte());
		if ($urandom_range(9) < 7) begin
			spot = $urandom_range(size);
			for (int j = 0; j < span && spot + j < size; j++)
				if (care_bits[j])
					body[spot + j] = pattern_bytes[8*j +: 8];
		end
		for (int i = 0; i < size; i++)
			add_item(body[i],
				(i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0),
				(i == size - 1) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0));
	endfunction

	function automatic void add_noise(int count);
		for (int i = 0; i < count; i++)
			add_item(BYTE_BITS'($urandom), $urandom_range(5) == 0, $urandom_range(5) == 0);
	endfunction

	task automatic run_phase(logic [CFG_DATA_BITS-1:0] lo, logic [CFG_DATA_BITS-1:0] hi,
			logic [CARE_BITS-1:0] care, logic [LEN_BITS-1:0] len, bit idle_in, bit idle_out);
		int target;
		load_pattern(lo, hi, care, len);
		input_idle = idle_in;
		output_idle = idle_out;
		target = items_queued + PHASE_ITEMS;
		while (items_queued < target) begin
			if ($urandom_range(4) != 0)
				add_search_range();
			else
				add_noise($urandom_range(1, 8));
		end
		settle();
	endtask

	task automatic run_backpressure();
		load_pattern({$urandom, $urandom}, {$urandom, $urandom}, CARE_BITS'($urandom), '0);
		input_idle = 1'b0;
		output_idle = 1'b0;
		hold_requests++;
		for (int i = 0; i < 100; i++)
			add_item(BYTE_BITS'($urandom), 1'b1, $urandom_range(1));
		settle();
	endtask

	initial begin
		pattern_bytes = '0;
		care_bits = '0;
		length_setting = '0;
		scan_position = 0;
		match_seen = 1'b0;
		foreach (recent_bytes[k])
			recent_bytes[k] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		input_idle = 1'b1;
		output_idle = 1'b1;
		load_pattern(64'h0000_0000_EFBE_ADDE, '0, 16'h000D, LEN_BITS'(4));
		add_item(8'h11, 1'b1, 1'b0);
		add_item(8'hDE, 1'b0, 1'b0);
		add_item(8'h77, 1'b0, 1'b0);
		add_item(8'hBE, 1'b0, 1'b0);
		add_item(8'hEF, 1'b0, 1'b0);
		add_item(8'h00, 1'b0, 1'b0);
		add_item(8'hFF, 1'b0, 1'b1);
		add_item(8'hDE, 1'b1, 1'b0);
		add_item(8'h55, 1'b0, 1'b0);
		add_item(8'hBE, 1'b0, 1'b1);
		add_item(8'hEF, 1'b1, 1'b1);
		add_item(8'hDE, 1'b0, 1'b0);
		add_item(8'h00, 1'b0, 1'b0);
		add_item(8'hBE, 1'b0, 1'b0);
		add_item(8'hEF, 1'b0, 1'b1);
		settle();

		load_pattern('1, '1, '1, '0);
		add_item(8'hFF, 1'b1, 1'b1);
		add_item(8'h00, 1'b0, 1'b1);
		add_item(8'h80, 1'b1, 1'b0);
		add_item(8'h01, 1'b0, 1'b1);
		settle();

		run_phase({$urandom, $urandom}, {$urandom, $urandom}, '1, LEN_BITS'(4), 1'b1, 1'b1);
		run_phase({$urandom, $urandom}, {$urandom, $urandom}, CARE_BITS'($urandom),
			LEN_BITS'(1), 1'b1, 1'b0);
		run_phase('1, '1, '1, LEN_BITS'(16), 1'b1, 1'b1);
		run_phase('0, '0, CARE_BITS'($urandom), LEN_BITS'(31), 1'b0, 1'b0);
		run_phase({$urandom, $urandom}, {$urandom, $urandom}, '0,
			LEN_BITS'($urandom_range(2, 15)), 1'b0, 1'b1);
		run_backpressure();
		run_phase({$urandom, $urandom}, {$urandom, $urandom}, CARE_BITS'($urandom),
			LEN_BITS'(17), 1'b1, 1'b1);
		run_phase({$urandom, $urandom}, {$urandom, $urandom}, CARE_BITS'($urandom),
			LEN_BITS'($urandom_range(1, 16)), 1'b1, 1'b1);
		run_phase({$urandom, $urandom}, {$urandom, $urandom}, '1,
			LEN_BITS'($urandom_range(2, 8)), 1'b1, 1'b1);
		run_phase({8{8'hA5}}, {8{8'h5A}}, CARE_BITS'($urandom), LEN_BITS'(8), 1'b1, 1'b1);
		run_phase({$urandom, $urandom}, {$urandom, $urandom}, CARE_BITS'($urandom),
			LEN_BITS'($urandom_range(17, 31)), 1'b0, 1'b0);

		if (expected_results.size() != 0)
			flag_error($sformatf("%0d expected results never arrived", expected_results.size()));
		$display("Scanned %0d bytes under %0d pattern settings, one long output hold-off included",
			items_sent, phases_run);
		$display("Checked %0d results: %0d matches, %0d ranges without a match, %0d mismatches",
			results_checked, found_count, miss_count, mismatches);
		if (mismatches == 0)
			$display("masked_byte_pattern_search test passed");
		else
			$display("masked_byte_pattern_search test failed");
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/mbps_pkg.sv
hdl/mbps_cell.sv
hdl/mbps_outq.sv
hdl/masked_byte_pattern_search.sv
verif/masked_byte_pattern_search_test.sv
